// File: hdl/mpk_pkg.sv
package mpk_pkg;

  // Sizing of the datapath
  localparam int K_MAX       = 16;
  localparam int PRICE_BITS  = 16;
  localparam int PROFIT_BITS = 20;
  localparam int TRADE_BITS  = 5;
  localparam int K_BITS      = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int VAL_RAW     = PRICE_BITS + K_BITS + 2;
  localparam int VAL_BITS    = (VAL_RAW > PROFIT_BITS + 1) ? VAL_RAW : PROFIT_BITS + 1;
  localparam int CNT_RAW     = $clog2(K_MAX + 1);
  localparam int CNT_BITS    = (CNT_RAW > TRADE_BITS) ? CNT_RAW : TRADE_BITS;

  // Reset value of the trade limit
  localparam logic [TRADE_BITS-1:0] TRADES_RESET = TRADE_BITS'(1);

  typedef logic signed [VAL_BITS-1:0] val_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic                  last_day;
  } in_item_t;

  typedef struct packed {
    logic [PROFIT_BITS-1:0] profit;
    logic                   too_short;
  } out_item_t;

  // Per-cycle control shared by all lanes
  typedef struct packed {
    logic load;
    logic first;
  } lane_ctrl_t;

endpackage

// File: hdl/max_profit_k_transactions.sv
// Best profit over a price sequence with at most max_trades buy-sell trades.
// Input channel (in_valid/in_ready/in_data): one price per item; last_day
// marks the final price of a sequence, and the next item starts a new one.
// Output channel (out_valid/out_ready/out_data): one item per sequence,
// profit and too_short, given only for an item with last_day set.
// Config channel (cfg_valid/cfg_ready/cfg_data): the trade limit, always
// ready; write it only while no sequence is in progress.
// Order: an accepted item waits in the input register; lane update and
// result register load as it advances, a last item only with the output
// register free. One item per cycle unless a last item waits; all lanes
// update in the same cycle, each with one add and one compare per entry.
// Reset: the trade limit returns to 1 and the block waits for the first
// price of a new sequence.
// Stall: while the output register is full and not taken, items without
// last_day keep flowing; a last item waits in the input register and
// in_ready drops until the pending result is taken.
module max_profit_k_transactions (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mpk_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mpk_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpk_pkg::TRADE_BITS-1:0]     cfg_data
);
  import mpk_pkg::*;

  logic                  s1_valid;
  in_item_t              s1;
  logic                  s1_adv;
  logic                  out_free;
  logic [1:0]            days_seen;
  logic [1:0]            days_seen_next;
  logic [TRADE_BITS-1:0] max_trades;
  lane_ctrl_t            lane_ctrl;
  val_t                  free [K_MAX];
  val_t                  free_next [K_MAX];
  out_item_t             result;

  // Handshake: last items need a free output slot, others always advance
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign s1_adv    = s1_valid && (!s1.last_day || out_free);
  assign in_ready  = !s1_valid || s1_adv;

  // Hold the trade limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_trades <= TRADES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_trades <= cfg_data;
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1 <= in_data;
    end
  end

  // Count prices of the sequence, saturating at two, cleared after the last
  always_comb begin
    if (s1.last_day) begin
      days_seen_next = 2'd0;
    end else if (days_seen == 2'd2) begin
      days_seen_next = days_seen;
    end else begin
      days_seen_next = days_seen + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      days_seen <= 2'd0;
    end else if (s1_adv) begin
      days_seen <= days_seen_next;
    end
  end

  assign lane_ctrl.load  = s1_adv;
  assign lane_ctrl.first = (days_seen == 2'd0);

  // One lane per trade count; lane zero buys from a zero free entry
  for (genvar k = 0; k < K_MAX; k++) begin : g_lane
    val_t prev;
    if (k == 0) begin : g_head
      assign prev = '0;
    end else begin : g_chain
      assign prev = free[k-1];
    end
    mpk_lane u_lane (
      .clk       (clk),
      .ctrl      (lane_ctrl),
      .price     (s1.price),
      .free_prev (prev),
      .free      (free[k]),
      .free_next (free_next[k])
    );
  end

  mpk_result u_result (
    .free_next  (free_next),
    .max_trades (max_trades),
    .too_short  (days_seen == 2'd0),
    .result     (result)
  );

  // Output register: load on a last item, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1.last_day) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.last_day) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_result_from_last : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_adv && s1.last_day))
    else $error("result appeared without a last item");

  a_short_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.too_short |-> out_data.profit == '0)
    else $error("short sequence gave a nonzero profit");

  a_days_sat : assert property (@(posedge clk) disable iff (rst)
    days_seen != 2'd3)
    else $error("day count passed saturation");

  a_seq_restart : assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1.last_day |=> days_seen == 2'd0)
    else $error("sequence not restarted after last item");

  a_last_waits : assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.last_day && out_valid && !out_ready |=> s1_valid)
    else $error("last item dropped while result pending");
`endif

endmodule

// File: hdl/mpk_lane.sv
module mpk_lane (
  input  logic                                  clk,
  input  mpk_pkg::lane_ctrl_t                   ctrl,
  input  logic [mpk_pkg::PRICE_BITS-1:0]        price,
  input  mpk_pkg::val_t                         free_prev,
  output mpk_pkg::val_t                         free,
  output mpk_pkg::val_t                         free_next
);
  import mpk_pkg::*;

  val_t holding;
  val_t holding_next;
  val_t p_ext;
  val_t sell;
  val_t buy;

  // Sell into the free entry, buy out of the previous free entry
  always_comb begin
    p_ext = val_t'({{(VAL_BITS - PRICE_BITS){1'b0}}, price});
    sell  = holding + p_ext;
    buy   = free_prev - p_ext;
    if (ctrl.first) begin
      free_next    = '0;
      holding_next = -p_ext;
    end else begin
      free_next    = (sell > free) ? sell : free;
      holding_next = (buy > holding) ? buy : holding;
    end
  end

  // Update on every item taken by the update stage
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      free    <= free_next;
      holding <= holding_next;
    end
  end

endmodule

// File: hdl/mpk_result.sv
module mpk_result (
  input  mpk_pkg::val_t                      free_next [mpk_pkg::K_MAX],
  input  logic [mpk_pkg::TRADE_BITS-1:0]     max_trades,
  input  logic                               too_short,
  output mpk_pkg::out_item_t                 result
);
  import mpk_pkg::*;

  localparam val_t CAP = val_t'((2 ** PROFIT_BITS) - 1);

  logic [CNT_BITS-1:0] t_ext;
  logic [CNT_BITS-1:0] t;
  val_t                pick;

  // Limit the trade count to the number of lanes
  always_comb begin
    t_ext = CNT_BITS'(max_trades);
    t     = (t_ext > CNT_BITS'(K_MAX)) ? CNT_BITS'(K_MAX) : t_ext;
  end

  // Select the free entry for the trade count; zero trades picks nothing
  always_comb begin
    pick = '0;
    for (int k = 0; k < K_MAX; k++) begin
      if (t == CNT_BITS'(k + 1)) begin
        pick = free_next[k];
      end
    end
  end

  // Clamp into the profit range
  always_comb begin
    result.too_short = too_short;
    if (too_short || pick < 0) begin
      result.profit = '0;
    end else if (pick > CAP) begin
      result.profit = '1;
    end else begin
      result.profit = PROFIT_BITS'(pick);
    end
  end

endmodule
